>>> rtl/phsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phsf_pkg: shared constants and types
// Sizes, register indexes, controller command/status structs.
// ----------------------------------------------------------------------------
package phsf_pkg;

    localparam int AVERAGE_DEPTH = 20;
    localparam int DRIFT_DEPTH   = 15;
    localparam int MIN_SLOPE     = 10;

    localparam int AW = $clog2(AVERAGE_DEPTH);
    localparam int RW = $clog2(DRIFT_DEPTH);
    localparam int ACW = $clog2(AVERAGE_DEPTH + 1);
    localparam int RCW = $clog2(DRIFT_DEPTH + 1);
    localparam int SUMW = 12 + ACW;

    localparam logic [1:0] REG_NEUTRAL   = 2'd0;
    localparam logic [1:0] REG_SLOPE     = 2'd1;
    localparam logic [1:0] REG_CAL       = 2'd2;
    localparam logic [1:0] REG_THRESHOLD = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture sample, update sum and store
        logic div_avg;  // start average divide
        logic div_ph;   // start pH divide
        logic div_step; // one restoring step
        logic push;     // write average into ring, start scan
        logic scan;     // one ring entry compare
        logic finish;   // form result
    } phsf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic scan_done;
    } phsf_sts_t;

endpackage

>>> rtl/phsf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phsf_ram: generic single-port RAM
// One registered read per cycle, plus a write when we is set.
// ----------------------------------------------------------------------------
module phsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

>>> rtl/phsf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phsf_ctrl: sequencer
// Steps one sample through sum update, two divides and the ring scan.
// ----------------------------------------------------------------------------
module phsf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output phsf_pkg::phsf_cmd_t cmd,
    input  phsf_pkg::phsf_sts_t sts
);
    import phsf_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_READ  = 9'b0_0000_0010,
        S_ADIV0 = 9'b0_0000_0100,
        S_ADIV  = 9'b0_0000_1000,
        S_PUSH  = 9'b0_0001_0000,
        S_SCAN  = 9'b0_0010_0000,
        S_PDIV0 = 9'b0_0100_0000,
        S_PDIV  = 9'b0_1000_0000,
        S_FIN   = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // sum and count update this cycle
                state_next = S_ADIV0;
            end
            S_ADIV0:
            begin
                cmd.div_avg = 1'b1;
                state_next  = S_ADIV;
            end
            S_ADIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                    state_next = S_PDIV0;
            end
            S_PDIV0:
            begin
                cmd.div_ph = 1'b1;
                state_next = S_PDIV;
            end
            S_PDIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

>>> rtl/phsf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phsf_dp: datapath
// Sample store, running sum, shared restoring divider, drift ring scan, pH.
// ----------------------------------------------------------------------------
module phsf_dp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_data,
    input  logic        cfg_hi,
    input  logic [11:0] sample,
    input  phsf_pkg::phsf_cmd_t cmd,
    output phsf_pkg::phsf_sts_t sts,
    output logic [15:0] filtered_level,
    output logic [15:0] drift_level,
    output logic        is_stable,
    output logic        became_stable,
    output logic [10:0] ph_hundredths,
    output logic        ph_valid
);
    import phsf_pkg::*;

    localparam int QW = 23; // dividend width: mag*100 + slope/2 < 2^23
    localparam logic [AW-1:0] ALAST = AW'(AVERAGE_DEPTH - 1);
    localparam logic [RW-1:0] RLAST = RW'(DRIFT_DEPTH - 1);

    // configuration registers
    logic [15:0] neutral_reg, slope_reg;
    logic        cal_reg;
    logic [11:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neutral_reg <= '0;
            slope_reg   <= 16'd1787;
            cal_reg     <= 1'b0;
            thr_reg     <= 12'd79;
        end
        else if (cfg_we && !cfg_hi)
        begin
            case (cfg_idx)
                REG_NEUTRAL:   neutral_reg <= cfg_data;
                REG_SLOPE:     slope_reg   <= cfg_data;
                REG_CAL:       cal_reg     <= cfg_data[0];
                REG_THRESHOLD: thr_reg     <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // sample store, read old entry then write new one
    logic [AW-1:0]   aidx_reg;
    logic [ACW-1:0]  acnt_reg;
    logic [SUMW-1:0] sum_reg;
    logic [11:0]     samp_reg, old_q;
    logic            aread_reg;

    phsf_ram #(.WIDTH(12), .DEPTH(AVERAGE_DEPTH)) u_avg_ram (
        .clk(clk), .we(aread_reg), .addr(aidx_reg), .wdata(samp_reg), .rdata(old_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aidx_reg  <= '0;
            acnt_reg  <= '0;
            sum_reg   <= '0;
            aread_reg <= 1'b0;
        end
        else
        begin
            aread_reg <= cmd.load;
            if (aread_reg)
            begin
                // old entry counts only once the store is full
                sum_reg <= sum_reg + SUMW'(samp_reg)
                         - ((acnt_reg == ACW'(AVERAGE_DEPTH)) ? SUMW'(old_q) : '0);
                aidx_reg <= (aidx_reg == ALAST) ? '0 : aidx_reg + 1'b1;
                if (acnt_reg != ACW'(AVERAGE_DEPTH))
                    acnt_reg <= acnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            samp_reg <= sample;
    end

    // shared restoring divider, one quotient bit per step
    logic [QW-1:0] num_reg, quo_reg;
    logic [16:0]   rem_reg;
    logic [15:0]   den_reg;
    logic [4:0]    dcnt_reg;
    logic [17:0]   trial;
    logic [16:0]   mag;
    logic [15:0]   avg_reg;
    logic          div_done, scan_done;

    assign mag = (avg_reg <= neutral_reg) ? 17'(neutral_reg - avg_reg)
                                          : 17'(avg_reg - neutral_reg);
    assign trial = {rem_reg, num_reg[QW-1]} - {2'b0, den_reg};
    assign div_done = (dcnt_reg == 5'd1);
    assign sts = '{div_done: div_done, scan_done: scan_done};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_avg || cmd.div_ph)
            dcnt_reg <= 5'(QW);
        else if (cmd.div_step && dcnt_reg != '0)
            dcnt_reg <= dcnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_avg)
        begin
            num_reg <= QW'({sum_reg, 4'b0}) + QW'(acnt_reg >> 1);
            den_reg <= 16'(acnt_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_ph)
        begin
            num_reg <= QW'(mag) * QW'(100) + QW'(slope_reg >> 1);
            den_reg <= slope_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[QW-2:0], 1'b0};
            if (!trial[17])
            begin
                rem_reg <= trial[16:0];
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[15:0], num_reg[QW-1]};
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.push)
            avg_reg <= quo_reg[15:0];
    end

    // drift ring: write average, then walk written entries for min/max
    logic [RW-1:0]  ridx_reg;
    logic [RCW-1:0] rcnt_reg, sidx_reg;
    logic [15:0]    lo_reg, hi_reg, ring_q;
    logic           rvalid_reg, pushed_reg;
    logic [RW-1:0]  raddr;

    assign raddr = pushed_reg ? ridx_reg : sidx_reg[RW-1:0];

    phsf_ram #(.WIDTH(16), .DEPTH(DRIFT_DEPTH)) u_ring_ram (
        .clk(clk), .we(pushed_reg), .addr(raddr), .wdata(avg_reg), .rdata(ring_q)
    );

    assign scan_done = !pushed_reg && !rvalid_reg && (sidx_reg >= rcnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ridx_reg   <= '0;
            rcnt_reg   <= '0;
            sidx_reg   <= '0;
            rvalid_reg <= 1'b0;
            pushed_reg <= 1'b0;
        end
        else
        begin
            pushed_reg <= cmd.push;
            rvalid_reg <= 1'b0;
            if (pushed_reg)
            begin
                ridx_reg <= (ridx_reg == RLAST) ? '0 : ridx_reg + 1'b1;
                if (rcnt_reg != RCW'(DRIFT_DEPTH))
                    rcnt_reg <= rcnt_reg + 1'b1;
                sidx_reg <= '0;
            end
            else if (cmd.scan && sidx_reg < rcnt_reg)
            begin
                rvalid_reg <= 1'b1;
                sidx_reg   <= sidx_reg + 1'b1;
            end
        end
    end

    // min/max accumulate; the walk stops at the fill count
    always_ff @(posedge clk)
    begin
        if (pushed_reg)
        begin
            lo_reg <= avg_reg;
            hi_reg <= avg_reg;
        end
        else if (rvalid_reg)
        begin
            if (ring_q < lo_reg) lo_reg <= ring_q;
            if (ring_q > hi_reg) hi_reg <= ring_q;
        end
    end

    // result register
    logic [15:0] drift;
    logic        stable, valid, below;
    logic [10:0] ph;
    logic        was_reg;

    assign drift = (rcnt_reg >= RCW'(3)) ? (hi_reg - lo_reg) : '0;
    assign stable = (drift <= 16'(thr_reg)) && (rcnt_reg == RCW'(DRIFT_DEPTH));
    assign valid = cal_reg && (slope_reg >= 16'(MIN_SLOPE));
    assign below = avg_reg > neutral_reg;

    always_comb
    begin
        if (!valid)
            ph = '0;
        else if (quo_reg >= QW'(700))
            ph = below ? 11'd0 : 11'd1400;
        else if (below)
            ph = 11'(11'd700 - quo_reg[10:0]);
        else
            ph = 11'(11'd700 + quo_reg[10:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            was_reg <= 1'b0;
        else if (cmd.finish)
            was_reg <= stable;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            filtered_level <= avg_reg;
            drift_level    <= drift;
            is_stable      <= stable;
            became_stable  <= stable && !was_reg;
            ph_hundredths  <= ph;
            ph_valid       <= valid;
        end
    end
endmodule

>>> rtl/ph_sensor_filter_stability_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ph_sensor_filter_stability_unit: pH probe filter with stability flag
// One 12-bit sample in, one filtered level / drift / pH result out.
// ----------------------------------------------------------------------------
// Each sample runs from acceptance to the result register through the sum
// update, the average divide, the one-entry-per-cycle walk over the drift
// ring RAM and the pH divide; the shared restoring divider (one bit per
// cycle) serves both divides. A new sample is taken once the controller is
// idle and the output register is empty or being read in the same cycle.
module ph_sensor_filter_stability_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] filtered_level,
    output logic [15:0] drift_level,
    output logic        is_stable,
    output logic        became_stable,
    output logic [10:0] ph_hundredths,
    output logic        ph_valid
);
    import phsf_pkg::*;

    phsf_cmd_t cmd;
    phsf_sts_t sts;

    phsf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
    );

    phsf_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index[1:0]),
        .cfg_data(cfg_data), .cfg_hi(|cfg_index[3:2]), .sample(sample),
        .cmd(cmd), .sts(sts), .filtered_level(filtered_level),
        .drift_level(drift_level), .is_stable(is_stable),
        .became_stable(became_stable), .ph_hundredths(ph_hundredths),
        .ph_valid(ph_valid)
    );
endmodule

>>> rtl/phsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phsf_checker: port-level checks
// Output beat rules and result field relations.
// ----------------------------------------------------------------------------
module phsf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] filtered_level,
    input logic        is_stable,
    input logic        became_stable,
    input logic [10:0] ph_hundredths,
    input logic        ph_valid
);
    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered_level))
        else $error("result changed while stalled");

    // became_stable implies is_stable
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && became_stable |-> is_stable)
        else $error("edge flag without stable");

    // pH within range and zero when invalid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ph_hundredths <= 11'd1400) && (ph_valid || ph_hundredths == 11'd0))
        else $error("bad pH field");

    // an accepted beat is not taken again next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken back to back");
endmodule

bind ph_sensor_filter_stability_unit phsf_checker u_phsf_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .filtered_level(filtered_level),
    .is_stable(is_stable), .became_stable(became_stable),
    .ph_hundredths(ph_hundredths), .ph_valid(ph_valid)
);

>>> sim/tb_ph_sensor_filter_stability_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ph_sensor_filter_stability_unit: self-checking bench for the pH filter
// Drives probe samples over valid/ready, predicts average, drift, stability
// and pH for every beat, and compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb_ph_sensor_filter_stability_unit;
    import phsf_pkg::*;

    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_CYCLES = 100;
    localparam logic [3:0] REG_UNUSED = 4'd9;

    typedef struct packed {
        logic [15:0] filtered_level;
        logic [15:0] drift_level;
        logic        is_stable;
        logic        became_stable;
        logic [10:0] ph_hundredths;
        logic        ph_valid;
    } probe_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [11:0] sample;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] filtered_level;
    logic [15:0] drift_level;
    logic        is_stable;
    logic        became_stable;
    logic [10:0] ph_hundredths;
    logic        ph_valid;

    ph_sensor_filter_stability_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .filtered_level(filtered_level), .drift_level(drift_level),
        .is_stable(is_stable), .became_stable(became_stable),
        .ph_hundredths(ph_hundredths), .ph_valid(ph_valid)
    );

    // predictor state
    logic [15:0] neutral_q;
    logic [15:0] slope_q;
    logic        cal_q;
    logic [11:0] thresh_q;
    logic [11:0] sample_hist [AVERAGE_DEPTH];
    int          hist_ptr;
    int          hist_fill;
    int          sample_sum;
    logic [15:0] avg_ring [DRIFT_DEPTH];
    int          ring_ptr;
    int          ring_fill;
    logic        prev_stable;

    probe_result_t expected_q[$];
    int  error_count;
    int  cycle_count;
    bit  sink_hold;
    bit  quiet_mode;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // global watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic void predictor_reset();
        neutral_q   = 16'd0;
        slope_q     = 16'd1787;
        cal_q       = 1'b0;
        thresh_q    = 12'd79;
        hist_ptr    = 0;
        hist_fill   = 0;
        sample_sum  = 0;
        ring_ptr    = 0;
        ring_fill   = 0;
        prev_stable = 1'b0;
    endfunction

    function automatic void apply_register(logic [3:0] idx, logic [15:0] val);
        case (idx)
            4'(REG_NEUTRAL):   neutral_q = val;
            4'(REG_SLOPE):     slope_q   = val;
            4'(REG_CAL):       cal_q     = val[0];
            4'(REG_THRESHOLD): thresh_q  = val[11:0];
            default: ;
        endcase
    endfunction

    function automatic probe_result_t filter_sample(logic [11:0] s);
        probe_result_t r;
        int avg, lo, hi, mag, q, ph;
        bit below, stable, valid;
        if (hist_fill >= AVERAGE_DEPTH)
            sample_sum -= sample_hist[hist_ptr];
        sample_hist[hist_ptr] = s;
        sample_sum += s;
        hist_ptr = (hist_ptr + 1) % AVERAGE_DEPTH;
        if (hist_fill < AVERAGE_DEPTH)
            hist_fill++;
        avg = (sample_sum * 16 + hist_fill / 2) / hist_fill;

        avg_ring[ring_ptr] = avg[15:0];
        ring_ptr = (ring_ptr + 1) % DRIFT_DEPTH;
        if (ring_fill < DRIFT_DEPTH)
            ring_fill++;
        lo = avg;
        hi = avg;
        if (ring_fill >= 3)
            for (int i = 0; i < ring_fill; i++)
            begin
                if (avg_ring[i] < lo) lo = avg_ring[i];
                if (avg_ring[i] > hi) hi = avg_ring[i];
            end
        stable = (hi - lo <= thresh_q) && ring_fill >= DRIFT_DEPTH;
        valid  = cal_q && slope_q >= MIN_SLOPE;
        ph = 0;
        if (valid)
        begin
            below = avg > neutral_q;
            mag = below ? avg - neutral_q : neutral_q - avg;
            q = (mag * 100 + slope_q / 2) / slope_q;
            if (below) ph = (q >= 700) ? 0 : 700 - q;
            else       ph = (q >= 700) ? 1400 : 700 + q;
        end
        r.filtered_level = avg[15:0];
        r.drift_level    = 16'(hi - lo);
        r.is_stable      = stable;
        r.became_stable  = stable && !prev_stable;
        r.ph_hundredths  = ph[10:0];
        r.ph_valid       = valid;
        prev_stable = stable;
        return r;
    endfunction

    // sink: random backpressure, plus an external long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= !sink_hold && (quiet_mode || $urandom_range(99) >= 17);
        end
    end

    // result checker
    initial
    begin
        probe_result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    error_count++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (filtered_level !== exp_r.filtered_level)
                    begin
                        $error("filtered_level exp %0d got %0d",
                               exp_r.filtered_level, filtered_level);
                        error_count++;
                    end
                    if (drift_level !== exp_r.drift_level)
                    begin
                        $error("drift_level exp %0d got %0d", exp_r.drift_level, drift_level);
                        error_count++;
                    end
                    if (is_stable !== exp_r.is_stable)
                    begin
                        $error("is_stable exp %0d got %0d", exp_r.is_stable, is_stable);
                        error_count++;
                    end
                    if (became_stable !== exp_r.became_stable)
                    begin
                        $error("became_stable exp %0d got %0d",
                               exp_r.became_stable, became_stable);
                        error_count++;
                    end
                    if (ph_hundredths !== exp_r.ph_hundredths)
                    begin
                        $error("ph_hundredths exp %0d got %0d",
                               exp_r.ph_hundredths, ph_hundredths);
                        error_count++;
                    end
                    if (ph_valid !== exp_r.ph_valid)
                    begin
                        $error("ph_valid exp %0d got %0d", exp_r.ph_valid, ph_valid);
                        error_count++;
                    end
                end
            end
        end
    end

    // send one sample beat; valid held until accepted
    task automatic send_sample(logic [11:0] s);
        // step past the previous beat's valid drop
        @(posedge clk);
        while (!quiet_mode && $urandom_range(99) < 17)
            @(posedge clk);
        in_valid <= 1'b1;
        sample   <= s;
        do @(posedge clk); while (!in_ready);
        expected_q.push_back(filter_sample(s));
        in_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [3:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_register(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_calibration(logic [15:0] n, logic [15:0] sl, logic c, logic [15:0] th);
        wait_drain();
        write_register(4'(REG_NEUTRAL), n);
        write_register(4'(REG_SLOPE), sl);
        write_register(4'(REG_CAL), {15'd0, c});
        write_register(4'(REG_THRESHOLD), th);
    endtask

    // directed: extremes, default uncalibrated, steady calibrated run
    task automatic test_directed();
        send_sample(12'd0);
        send_sample(12'hFFF);
        send_sample(12'd0);
        send_sample(12'hFFF);
        set_calibration(16'd32000, 16'd1787, 1'b1, 16'd79);
        for (int i = 0; i < 18; i++)
            send_sample(12'd2000);
    endtask

    // pH clamps, invalid slope, ignored index, wide values
    task automatic test_ph_edges();
        set_calibration(16'd0, 16'd10, 1'b1, 16'hFFFF);
        send_sample(12'hFFF);
        set_calibration(16'hFFFF, 16'd9, 1'b1, 16'd0);
        send_sample(12'd0);
        set_calibration(16'hFFFF, 16'd1, 1'b1, 16'd0);
        send_sample(12'd0);
        set_calibration(16'hFFFF, 16'hFFFF, 1'b1, 16'd4095);
        send_sample(12'd100);
        wait_drain();
        write_register(REG_UNUSED, 16'h1234);
        write_register(4'(REG_CAL), 16'hFFFE);
        send_sample(12'd5);
    endtask

    // backpressure: sink stalls long, sender keeps offering
    task automatic test_backpressure();
        set_calibration(16'd30000, 16'd2000, 1'b1, 16'd200);
        sink_hold = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                sink_hold = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_sample(12'($urandom_range(4095)));
        join
        wait_drain();
    endtask

    // random phases over several settings, mostly smooth signals
    task automatic test_random();
        int base;
        for (int ph = 0; ph < 10; ph++)
        begin
            set_calibration(16'($urandom_range(65535)), 16'($urandom_range(3000)),
                            1'($urandom_range(1)), 16'($urandom_range(400)));
            quiet_mode = (ph == 4);
            base = $urandom_range(4095);
            for (int i = 0; i < 52; i++)
            begin
                if ($urandom_range(9) < 2)
                    send_sample(12'($urandom_range(4095)));
                else
                begin
                    base = base + $urandom_range(8) - 4;
                    if (base < 0) base = 0;
                    if (base > 4095) base = 4095;
                    send_sample(12'(base));
                end
            end
            quiet_mode = 1'b0;
        end
    endtask

    initial
    begin
        error_count = 0;
        sink_hold   = 1'b0;
        quiet_mode  = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 4'd0;
        cfg_data  = 16'd0;
        in_valid  = 1'b0;
        sample    = 12'd0;
        predictor_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_ph_edges();
        test_backpressure();
        test_random();
        wait_drain();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
